// File: design/alr_pkg.sv
// Shared types and constants for the audio loop recorder.
// No dependencies; imported by alr_dp, alr_ctrl, the top level and the testbench.
`default_nettype none
package alr_pkg;

  // Sample format
  localparam int SMP_W = 24;

  // Item opcodes (carried in tuser)
  localparam logic [2:0] OP_FRAME = 3'd0;
  localparam logic [2:0] OP_REC   = 3'd1;
  localparam logic [2:0] OP_PLAY  = 3'd2;
  localparam logic [2:0] OP_ODUB  = 3'd3;
  localparam logic [2:0] OP_UNDO  = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  // Looper modes
  localparam logic [2:0] MODE_EMPTY = 3'd0;
  localparam logic [2:0] MODE_REC   = 3'd1;
  localparam logic [2:0] MODE_PLAY  = 3'd2;
  localparam logic [2:0] MODE_STOP  = 3'd3;
  localparam logic [2:0] MODE_ODUB  = 3'd4;

  // Fade and loop limits
  localparam int FADE_DIV = 4;
  localparam int MIN_LOOP = 2;

  // Output sample source
  localparam logic [1:0] OSEL_ZERO   = 2'd0;
  localparam logic [1:0] OSEL_SAMPLE = 2'd1;
  localparam logic [1:0] OSEL_MIX    = 2'd2;

  // Loop store write data source
  localparam logic [1:0] WSEL_SAMPLE = 2'd0;
  localparam logic [1:0] WSEL_MIX    = 2'd1;
  localparam logic [1:0] WSEL_QUO    = 2'd2;
  localparam logic [1:0] WSEL_UNDO   = 2'd3;

  // Status fields that travel with each result
  typedef struct packed {
    logic [2:0]  mode;
    logic [16:0] loop_length;
    logic [2:0]  undo_available;
  } alr_info_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load_in;
    logic      mix_load;
    logic      div_start;
    logic      out_load;
    logic      loop_we;
    logic [1:0] loop_wsel;
    logic      undo_we;
    logic [1:0] out_sel;
    alr_info_t info;
  } alr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_busy;
  } alr_stat_t;

endpackage
`default_nettype wire

// File: design/alr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module alr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/alr_div.sv
// Bit-serial signed divider by a small unsigned divisor, truncating toward zero.
// One quotient bit per cycle; no package dependencies.
`default_nettype none
module alr_div #(
  parameter int DW = 38,
  parameter int FW = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] dividend,
  input  wire logic [FW-1:0]        divisor,
  output      logic                 done,
  output      logic [23:0]          quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    q_r, q_nxt;
  logic [FW:0]      rem_r, rem_nxt;
  logic [FW-1:0]    d_r, d_nxt;
  logic             neg_r, neg_nxt;
  logic [FW:0]      rem_sh;
  logic [DW-1:0]    q_signed;

  // Shift one dividend bit into the remainder and try a subtract
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[FW-1:0], q_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW);
      q_nxt    = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
      neg_nxt  = dividend[DW-1];
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = rem_sh - {1'b0, d_r};
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  // Restore the sign of the magnitude quotient
  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;
  assign quotient = q_signed[23:0];
  assign done     = done_r;

endmodule
`default_nettype wire

// File: design/alr_dp.sv
// Looper datapath: loop and undo stores, mixer, fade dividers, output register.
// Depends on alr_pkg, alr_ram and alr_div.
`default_nettype none
module alr_dp
  import alr_pkg::*;
#(
  parameter int LOOP_DEPTH   = 65536,
  parameter int UNDO_SLOTS   = 4,
  parameter int FADE_SAMPLES = 64,
  parameter int CHANNELS     = 2
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire alr_cmd_t                                cmd,
  output      alr_stat_t                               stat,
  input  wire logic [$clog2(LOOP_DEPTH)-1:0]           loop_raddr,
  input  wire logic [$clog2(LOOP_DEPTH)-1:0]           loop_waddr,
  input  wire logic [$clog2(UNDO_SLOTS*LOOP_DEPTH)-1:0] undo_raddr,
  input  wire logic [$clog2(UNDO_SLOTS*LOOP_DEPTH)-1:0] undo_waddr,
  input  wire logic [((FADE_SAMPLES > 1) ? $clog2(FADE_SAMPLES) : 1)-1:0] fade_mult,
  input  wire logic [$clog2(FADE_SAMPLES+1)-1:0]       fade_div,
  input  wire logic [47:0]                             in_tdata,
  output      logic                                    out_tvalid,
  input  wire logic                                    out_tready,
  output      logic [71:0]                             out_tdata
);

  localparam int AW  = $clog2(LOOP_DEPTH);
  localparam int UD  = UNDO_SLOTS * LOOP_DEPTH;
  localparam int UAW = $clog2(UD);
  localparam int IW  = (FADE_SAMPLES > 1) ? $clog2(FADE_SAMPLES) : 1;
  localparam int FW  = $clog2(FADE_SAMPLES + 1);
  localparam int PW  = SMP_W + IW + 1;
  localparam int RW  = SMP_W * CHANNELS;

  localparam logic signed [SMP_W:0] SAT_MAX = (SMP_W+1)'(8388607);
  localparam logic signed [SMP_W:0] SAT_MIN = -(SMP_W+1)'(8388608);

  logic signed [SMP_W-1:0] smp_r [CHANNELS];
  logic signed [SMP_W-1:0] mix_r [CHANNELS];
  logic [SMP_W-1:0]        quo   [CHANNELS];
  logic [CHANNELS-1:0]     div_done;
  logic [RW-1:0]           loop_rdata, loop_wdata, undo_rdata;
  logic [SMP_W-1:0]        osmp  [2];
  logic                    out_valid_r;
  logic [71:0]             out_data_r;

  alr_ram #(.WIDTH(RW), .DEPTH(LOOP_DEPTH)) u_loop_ram (
    .clk   (clk),
    .we    (cmd.loop_we),
    .waddr (loop_waddr[AW-1:0]),
    .wdata (loop_wdata),
    .raddr (loop_raddr[AW-1:0]),
    .rdata (loop_rdata)
  );

  // Undo store takes loop store read data directly
  alr_ram #(.WIDTH(RW), .DEPTH(UD)) u_undo_ram (
    .clk   (clk),
    .we    (cmd.undo_we),
    .waddr (undo_waddr[UAW-1:0]),
    .wdata (loop_rdata),
    .raddr (undo_raddr[UAW-1:0]),
    .rdata (undo_rdata)
  );

  // Per-channel lanes: sample hold, saturating mix, fade scaling
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic signed [SMP_W-1:0] rd;
    logic signed [SMP_W:0]   sum;
    logic signed [SMP_W-1:0] sat;
    logic signed [PW-1:0]    prod;

    assign rd   = loop_rdata[SMP_W*c +: SMP_W];
    assign sum  = (SMP_W+1)'(rd) + (SMP_W+1)'(smp_r[c]);
    assign sat  = (sum > SAT_MAX) ? SAT_MAX[SMP_W-1:0] :
                  (sum < SAT_MIN) ? SAT_MIN[SMP_W-1:0] : sum[SMP_W-1:0];
    assign prod = rd * $signed({1'b0, fade_mult});

    // Hold the accepted sample and the mix result
    always_ff @(posedge clk) begin
      if (cmd.load_in) begin
        smp_r[c] <= in_tdata[SMP_W*c +: SMP_W];
      end
      if (cmd.mix_load) begin
        mix_r[c] <= sat;
      end
    end

    alr_div #(.DW(PW), .FW(FW)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_start),
      .dividend (prod),
      .divisor  (fade_div),
      .done     (div_done[c]),
      .quotient (quo[c])
    );

    // Select loop store write data
    always_comb begin
      case (cmd.loop_wsel)
        WSEL_SAMPLE: loop_wdata[SMP_W*c +: SMP_W] = smp_r[c];
        WSEL_MIX:    loop_wdata[SMP_W*c +: SMP_W] = mix_r[c];
        WSEL_QUO:    loop_wdata[SMP_W*c +: SMP_W] = quo[c];
        WSEL_UNDO:   loop_wdata[SMP_W*c +: SMP_W] = undo_rdata[SMP_W*c +: SMP_W];
        default:     loop_wdata[SMP_W*c +: SMP_W] = smp_r[c];
      endcase
    end
  end

  // Pick output samples; a missing channel reads zero
  for (genvar c = 0; c < 2; c++) begin : g_osmp
    if (c < CHANNELS) begin : g_on
      always_comb begin
        case (cmd.out_sel)
          OSEL_SAMPLE: osmp[c] = smp_r[c];
          OSEL_MIX:    osmp[c] = mix_r[c];
          default:     osmp[c] = '0;
        endcase
      end
    end else begin : g_off
      assign osmp[c] = '0;
    end
  end

  // Output register: load a result, clear on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, cmd.info.undo_available, cmd.info.loop_length,
                     cmd.info.mode, osmp[1], osmp[0]};
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign stat.div_done = &div_done;
  assign stat.out_busy = out_valid_r & ~out_tready;

endmodule
`default_nettype wire

// File: design/alr_ctrl.sv
// Looper controller: mode state, positions, undo ring and the sequencer
// that drives frames, fades and snapshot copies. Depends on alr_pkg.
`default_nettype none
module alr_ctrl
  import alr_pkg::*;
#(
  parameter int LOOP_DEPTH   = 65536,
  parameter int UNDO_SLOTS   = 4,
  parameter int FADE_SAMPLES = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output      logic                                    in_tready,
  input  wire logic [2:0]                              in_tuser,
  input  wire logic                                    cfg_wen,
  input  wire logic [16:0]                             cfg_wdata,
  output      alr_cmd_t                                cmd,
  input  wire alr_stat_t                               stat,
  output      logic [$clog2(LOOP_DEPTH)-1:0]           loop_raddr,
  output      logic [$clog2(LOOP_DEPTH)-1:0]           loop_waddr,
  output      logic [$clog2(UNDO_SLOTS*LOOP_DEPTH)-1:0] undo_raddr,
  output      logic [$clog2(UNDO_SLOTS*LOOP_DEPTH)-1:0] undo_waddr,
  output      logic [((FADE_SAMPLES > 1) ? $clog2(FADE_SAMPLES) : 1)-1:0] fade_mult,
  output      logic [$clog2(FADE_SAMPLES+1)-1:0]       fade_div
);

  localparam int AW  = $clog2(LOOP_DEPTH);
  localparam int LW  = $clog2(LOOP_DEPTH + 1);
  localparam int UAW = $clog2(UNDO_SLOTS * LOOP_DEPTH);
  localparam int SW  = (UNDO_SLOTS > 1) ? $clog2(UNDO_SLOTS) : 1;
  localparam int NW  = $clog2(UNDO_SLOTS + 1);
  localparam int IW  = (FADE_SAMPLES > 1) ? $clog2(FADE_SAMPLES) : 1;
  localparam int FW  = $clog2(FADE_SAMPLES + 1);
  localparam int LCW = ((LW > 17) ? LW : 17) + 1;
  localparam int CW  = ((LW > FW) ? LW : FW) + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_PMIX  = 4'd2;
  localparam logic [3:0] S_PWB   = 4'd3;
  localparam logic [3:0] S_FINIT = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FST   = 4'd6;
  localparam logic [3:0] S_FWAIT = 4'd7;
  localparam logic [3:0] S_FWR   = 4'd8;
  localparam logic [3:0] S_COPY  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]     state_r, state_nxt;
  logic [2:0]     op_r, op_nxt;
  logic [2:0]     mode_r, mode_nxt;
  logic [LW-1:0]  rec_r, rec_nxt;
  logic [AW-1:0]  pp_r, pp_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic [16:0]    max_r;
  logic [1:0]     osel_r, osel_nxt;
  logic [FW-1:0]  fcnt_r, fcnt_nxt;
  logic [IW-1:0]  fi_r, fi_nxt;
  logic           side_r, side_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [LW-1:0]  k_r, k_nxt;
  logic [LW-1:0]  n_r, n_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  paddr_r, paddr_nxt;
  logic [UAW-1:0] base_r, base_nxt;
  logic           dir_r, dir_nxt;

  logic [LCW-1:0] lim_wide;
  logic [LW-1:0]  limit;
  logic [LW-1:0]  copy_n;
  logic [LW-1:0]  q4;
  logic [LW-1:0]  pp_ext;
  logic [AW-1:0]  pp_eff;
  logic [LW-1:0]  pp_inc;
  logic [SW-1:0]  slot_prev, slot_next, use_slot;
  logic [LW-1:0]  tail_idx;
  logic           accept;

  assign accept    = in_tvalid & in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Effective loop limit, clamped to one .. store depth
  always_comb begin
    lim_wide = LCW'(max_r);
    if (max_r == 17'd0) begin
      lim_wide = LCW'(1);
    end else if (lim_wide > LCW'(LOOP_DEPTH)) begin
      lim_wide = LCW'(LOOP_DEPTH);
    end
  end
  assign limit  = LW'(lim_wide);
  assign copy_n = (len_r < limit) ? len_r : limit;

  assign q4        = len_r >> 2;
  assign pp_ext    = LW'(pp_r);
  assign pp_eff    = (pp_ext >= len_r) ? '0 : pp_r;
  assign pp_inc    = LW'(pp_r) + 1'b1;
  assign slot_prev = (slot_r == '0) ? SW'(UNDO_SLOTS - 1) : slot_r - 1'b1;
  assign slot_next = (slot_r == SW'(UNDO_SLOTS - 1)) ? '0 : slot_r + 1'b1;
  assign use_slot  = (op_r == OP_UNDO) ? slot_prev : slot_r;
  assign tail_idx  = len_r - 1'b1 - LW'(fi_r);

  assign fade_mult = fi_r;
  assign fade_div  = fcnt_r;

  // Sequencer and looper state update
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    mode_nxt  = mode_r;
    rec_nxt   = rec_r;
    pp_nxt    = pp_r;
    len_nxt   = len_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    osel_nxt  = osel_r;
    fcnt_nxt  = fcnt_r;
    fi_nxt    = fi_r;
    side_nxt  = side_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    pend_nxt  = pend_r;
    paddr_nxt = paddr_r;
    base_nxt  = base_r;
    dir_nxt   = dir_r;

    cmd            = '0;
    cmd.loop_wsel  = WSEL_SAMPLE;
    cmd.out_sel    = osel_r;
    cmd.info.mode           = mode_r;
    cmd.info.loop_length    = 17'(len_r);
    cmd.info.undo_available = 3'(cnt_r);
    loop_raddr = idx_r;
    loop_waddr = idx_r;
    undo_raddr = base_r + UAW'(k_r[AW-1:0]);
    undo_waddr = base_r + UAW'(paddr_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          op_nxt      = in_tuser;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        osel_nxt  = (op_r == OP_FRAME) ? OSEL_SAMPLE : OSEL_ZERO;
        state_nxt = S_OUT;
        k_nxt     = '0;
        pend_nxt  = 1'b0;
        n_nxt     = copy_n;
        base_nxt  = UAW'(use_slot) * UAW'(LOOP_DEPTH);
        case (op_r)
          OP_FRAME: begin
            if (mode_r == MODE_REC) begin
              if (rec_r < limit) begin
                // Store the frame and advance
                cmd.loop_we   = 1'b1;
                cmd.loop_wsel = WSEL_SAMPLE;
                loop_waddr    = rec_r[AW-1:0];
                rec_nxt       = rec_r + 1'b1;
              end else begin
                // Full: close at the limit, drop this frame
                len_nxt   = limit;
                pp_nxt    = '0;
                mode_nxt  = MODE_PLAY;
                state_nxt = S_FINIT;
              end
            end else if ((mode_r == MODE_PLAY || mode_r == MODE_ODUB) && len_r != '0) begin
              loop_raddr = pp_eff;
              pp_nxt     = pp_eff;
              state_nxt  = S_PMIX;
            end
          end
          OP_REC: begin
            if (mode_r == MODE_EMPTY) begin
              rec_nxt  = '0;
              pp_nxt   = '0;
              len_nxt  = '0;
              mode_nxt = MODE_REC;
            end else if (mode_r == MODE_REC) begin
              if (rec_r < LW'(MIN_LOOP)) begin
                rec_nxt  = '0;
                len_nxt  = '0;
                mode_nxt = MODE_EMPTY;
              end else begin
                len_nxt   = rec_r;
                pp_nxt    = '0;
                mode_nxt  = MODE_PLAY;
                state_nxt = S_FINIT;
              end
            end
          end
          OP_PLAY: begin
            if (mode_r == MODE_PLAY || mode_r == MODE_ODUB) begin
              mode_nxt = MODE_STOP;
            end else if (mode_r == MODE_STOP && len_r != '0) begin
              mode_nxt = MODE_PLAY;
            end
          end
          OP_ODUB: begin
            if (mode_r == MODE_PLAY) begin
              // Snapshot into the current slot
              dir_nxt   = 1'b0;
              slot_nxt  = slot_next;
              if (cnt_r != NW'(UNDO_SLOTS)) begin
                cnt_nxt = cnt_r + 1'b1;
              end
              mode_nxt  = MODE_ODUB;
              state_nxt = S_COPY;
            end else if (mode_r == MODE_ODUB) begin
              mode_nxt = MODE_PLAY;
            end
          end
          OP_UNDO: begin
            if (cnt_r != '0 && len_r != '0) begin
              // Restore from the previous slot
              dir_nxt   = 1'b1;
              slot_nxt  = slot_prev;
              cnt_nxt   = cnt_r - 1'b1;
              if (mode_r == MODE_ODUB) begin
                mode_nxt = MODE_PLAY;
              end
              state_nxt = S_COPY;
            end
          end
          OP_CLEAR: begin
            mode_nxt = MODE_EMPTY;
            rec_nxt  = '0;
            pp_nxt   = '0;
            len_nxt  = '0;
            slot_nxt = '0;
            cnt_nxt  = '0;
          end
          default: begin
          end
        endcase
      end

      S_PMIX: begin
        cmd.mix_load = 1'b1;
        state_nxt    = S_PWB;
      end

      S_PWB: begin
        // Write back the overdub mix and advance the play position
        if (mode_r == MODE_ODUB) begin
          cmd.loop_we   = 1'b1;
          cmd.loop_wsel = WSEL_MIX;
        end
        loop_waddr = pp_r;
        pp_nxt     = (pp_inc >= len_r) ? '0 : pp_inc[AW-1:0];
        osel_nxt   = OSEL_MIX;
        state_nxt  = S_OUT;
      end

      S_FINIT: begin
        if (len_r < LW'(FADE_DIV)) begin
          state_nxt = S_OUT;
        end else begin
          fcnt_nxt  = (CW'(q4) > CW'(FADE_SAMPLES)) ? FW'(FADE_SAMPLES) : FW'(q4);
          fi_nxt    = '0;
          side_nxt  = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_FRD;
        end
      end

      S_FRD: begin
        loop_raddr = idx_r;
        state_nxt  = S_FST;
      end

      S_FST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_FWAIT;
      end

      S_FWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_FWR;
        end
      end

      S_FWR: begin
        // Write the scaled entry, then move to its mirror, to the next pair or to the result
        cmd.loop_we   = 1'b1;
        cmd.loop_wsel = WSEL_QUO;
        loop_waddr    = idx_r;
        if (!side_r) begin
          side_nxt  = 1'b1;
          idx_nxt   = tail_idx[AW-1:0];
          state_nxt = S_FRD;
        end else if (FW'(fi_r) + FW'(1) == fcnt_r) begin
          state_nxt = S_OUT;
        end else begin
          fi_nxt    = fi_r + 1'b1;
          side_nxt  = 1'b0;
          idx_nxt   = AW'(fi_r) + 1'b1;
          state_nxt = S_FRD;
        end
      end

      S_COPY: begin
        // Stream one entry a cycle between the stores
        if (pend_r) begin
          if (dir_r) begin
            cmd.loop_we   = 1'b1;
            cmd.loop_wsel = WSEL_UNDO;
            loop_waddr    = paddr_r;
          end else begin
            cmd.undo_we = 1'b1;
          end
        end
        loop_raddr = k_r[AW-1:0];
        if (k_r < n_r) begin
          pend_nxt  = 1'b1;
          paddr_nxt = k_r[AW-1:0];
          k_nxt     = k_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_EMPTY;
      rec_r   <= '0;
      pp_r    <= '0;
      len_r   <= '0;
      slot_r  <= '0;
      cnt_r   <= '0;
      max_r   <= 17'd65536;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      rec_r   <= rec_nxt;
      pp_r    <= pp_nxt;
      len_r   <= len_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wen) begin
        max_r <= cfg_wdata;
      end
    end
    op_r    <= op_nxt;
    osel_r  <= osel_nxt;
    fcnt_r  <= fcnt_nxt;
    fi_r    <= fi_nxt;
    side_r  <= side_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    pend_r  <= pend_nxt;
    paddr_r <= paddr_nxt;
    base_r  <= base_nxt;
    dir_r   <= dir_nxt;
  end

endmodule
`default_nettype wire

// File: design/audio_loop_recorder_overdub_unit.sv
// Top level of the stereo audio looper.
// Depends on alr_pkg, alr_ctrl and alr_dp (which holds alr_ram and alr_div).
//
// Each input transfer is one sample frame or one command, selected by in_tuser, and gives
// exactly one result transfer. The block takes one item at a time: a command without store
// work and a frame while empty, recording or stopped go straight on to their result; a frame
// while playing or overdubbing runs loop store read, mix, write-back and result, the read
// going through the registered read port of the single loop store.
// Record-close and loop-full items run the splice fade:
// for each of F = min(FADE_SAMPLES, length/4) head/tail pairs two read-multiply-divide-write
// passes through the bit-serial divider, whose dividend is PW = 25 + log2(FADE_SAMPLES) bits
// wide. Overdub start and undo copy min(loop length, limit) entries between the loop and
// undo stores at one entry per cycle. A result that cannot leave holds the block in its last
// step. A new item is accepted while the previous result waits in the output register. The
// loop and undo stores are not cleared at reset; max_loop_samples resets to 65536.
`default_nettype none
module audio_loop_recorder_overdub_unit
  import alr_pkg::*;
#(
  parameter int LOOP_DEPTH   = 65536,
  parameter int UNDO_SLOTS   = 4,
  parameter int FADE_SAMPLES = 64,
  parameter int CHANNELS     = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // sample_ch0 [23:0], sample_ch1 [47:24]
  input  wire logic [2:0]  in_tuser,   // opcode [2:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [71:0] out_tdata,  // out_ch0 [23:0], out_ch1 [47:24], mode [50:48],
                                       // loop_length [67:51], undo_available [70:68]
  input  wire logic        cfg_wen,
  input  wire logic [16:0] cfg_wdata   // max_loop_samples
);

  localparam int AW  = $clog2(LOOP_DEPTH);
  localparam int UAW = $clog2(UNDO_SLOTS * LOOP_DEPTH);
  localparam int IW  = (FADE_SAMPLES > 1) ? $clog2(FADE_SAMPLES) : 1;
  localparam int FW  = $clog2(FADE_SAMPLES + 1);

  alr_cmd_t       cmd;
  alr_stat_t      stat;
  logic [AW-1:0]  loop_raddr, loop_waddr;
  logic [UAW-1:0] undo_raddr, undo_waddr;
  logic [IW-1:0]  fade_mult;
  logic [FW-1:0]  fade_div;

  alr_ctrl #(
    .LOOP_DEPTH   (LOOP_DEPTH),
    .UNDO_SLOTS   (UNDO_SLOTS),
    .FADE_SAMPLES (FADE_SAMPLES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .loop_raddr (loop_raddr),
    .loop_waddr (loop_waddr),
    .undo_raddr (undo_raddr),
    .undo_waddr (undo_waddr),
    .fade_mult  (fade_mult),
    .fade_div   (fade_div)
  );

  alr_dp #(
    .LOOP_DEPTH   (LOOP_DEPTH),
    .UNDO_SLOTS   (UNDO_SLOTS),
    .FADE_SAMPLES (FADE_SAMPLES),
    .CHANNELS     (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .loop_raddr (loop_raddr),
    .loop_waddr (loop_waddr),
    .undo_raddr (undo_raddr),
    .undo_waddr (undo_waddr),
    .fade_mult  (fade_mult),
    .fade_div   (fade_div),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: tb/audio_loop_recorder_overdub_unit_tb.sv
// Self-checking testbench for the stereo audio looper (record, play, overdub, undo, clear).
// Depends on alr_pkg and audio_loop_recorder_overdub_unit; an inline looper predictor
// checks every result transfer against the expected one.
`timescale 1ns / 100ps
`default_nettype none
module audio_loop_recorder_overdub_unit_tb;
  import alr_pkg::*;

  localparam int DEPTH      = 65536;
  localparam int SLOTS      = 4;
  localparam int FADE_MAX   = 64;
  localparam int S24_HI     = 8388607;
  localparam int S24_LO     = -8388608;
  localparam int CYCLE_CAP  = 2000000;
  localparam int ITEM_GOAL  = 1600;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic signed [23:0] ch0;
    logic signed [23:0] ch1;
    logic [2:0]         mode;
    logic [16:0]        loop_len;
    logic [2:0]         undo_cnt;
  } looper_result_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [23:0] s0;
    logic signed [23:0] s1;
    bit                 typed;
    looper_result_t     res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // sample_ch0 [23:0], sample_ch1 [47:24]
  logic [2:0]  in_tuser = '0;   // opcode [2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // out_ch0 [23:0], out_ch1 [47:24], mode [50:48],
                                // loop_length [67:51], undo_available [70:68]
  logic        cfg_wen = 1'b0;
  logic [16:0] cfg_wdata = '0;  // max_loop_samples

  audio_loop_recorder_overdub_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor state
  int          loop0 [DEPTH];
  int          loop1 [DEPTH];
  int          snap0 [int];
  int          snap1 [int];
  logic [2:0]  p_mode;
  int unsigned p_rec_pos, p_play_pos, p_len, p_slot, p_undo;
  logic [16:0] p_max_samples;

  looper_result_t expected_q[$];
  int  fail_count = 0;
  int  sent_count = 0;
  int  recv_count = 0;
  int  session_count = 0;
  int  cycle_count = 0;

  function automatic int sat24(int v);
    if (v > S24_HI) return S24_HI;
    if (v < S24_LO) return S24_LO;
    return v;
  endfunction

  function automatic int unsigned loop_limit();
    if (p_max_samples < 1) return 1;
    if (p_max_samples > DEPTH) return DEPTH;
    return 32'(p_max_samples);
  endfunction

  function automatic int unsigned copy_len();
    return (p_len < loop_limit()) ? p_len : loop_limit();
  endfunction

  function automatic void clear_looper();
    p_mode = MODE_EMPTY;
    p_rec_pos = 0;
    p_play_pos = 0;
    p_len = 0;
    p_slot = 0;
    p_undo = 0;
  endfunction

  // Close the loop: fade head and tail toward zero, then start playing
  function automatic void close_loop(int unsigned len);
    int unsigned fade;
    int unsigned t;
    longint      v;
    longint      li;
    longint      lf;
    p_len = len;
    if (len >= FADE_DIV) begin
      fade = len / FADE_DIV;
      if (fade > FADE_MAX) fade = FADE_MAX;
      lf = longint'(fade);
      for (int unsigned i = 0; i < fade; i++) begin
        t = len - 1 - i;
        li = longint'(i);
        v = loop0[i];  loop0[i] = int'((v * li) / lf);
        v = loop1[i];  loop1[i] = int'((v * li) / lf);
        v = loop0[t];  loop0[t] = int'((v * li) / lf);
        v = loop1[t];  loop1[t] = int'((v * li) / lf);
      end
    end
    p_play_pos = 0;
    p_mode = MODE_PLAY;
  endfunction

  function automatic looper_result_t predict_looper(logic [2:0] op, int s0, int s1);
    looper_result_t r;
    int unsigned    n;
    int             m0, m1;
    r.ch0 = '0;
    r.ch1 = '0;
    if (op == OP_REC) begin
      if (p_mode == MODE_EMPTY) begin
        p_rec_pos = 0; p_play_pos = 0; p_len = 0; p_mode = MODE_REC;
      end else if (p_mode == MODE_REC) begin
        if (p_rec_pos < MIN_LOOP) begin
          p_rec_pos = 0; p_len = 0; p_mode = MODE_EMPTY;
        end else begin
          close_loop(p_rec_pos);
        end
      end
    end else if (op == OP_PLAY) begin
      if (p_mode == MODE_PLAY || p_mode == MODE_ODUB) p_mode = MODE_STOP;
      else if (p_mode == MODE_STOP && p_len > 0) p_mode = MODE_PLAY;
    end else if (op == OP_ODUB) begin
      if (p_mode == MODE_PLAY) begin
        n = copy_len();
        for (int unsigned i = 0; i < n; i++) begin
          snap0[p_slot * DEPTH + i] = loop0[i];
          snap1[p_slot * DEPTH + i] = loop1[i];
        end
        p_slot = (p_slot + 1) % SLOTS;
        if (p_undo < SLOTS) p_undo++;
        p_mode = MODE_ODUB;
      end else if (p_mode == MODE_ODUB) begin
        p_mode = MODE_PLAY;
      end
    end else if (op == OP_UNDO) begin
      if (p_undo > 0 && p_len > 0) begin
        p_slot = (p_slot + SLOTS - 1) % SLOTS;
        n = copy_len();
        for (int unsigned i = 0; i < n; i++) begin
          loop0[i] = snap0[p_slot * DEPTH + i];
          loop1[i] = snap1[p_slot * DEPTH + i];
        end
        p_undo--;
        if (p_mode == MODE_ODUB) p_mode = MODE_PLAY;
      end
    end else if (op == OP_CLEAR) begin
      clear_looper();
    end else if (op == OP_FRAME) begin
      r.ch0 = 24'(s0);
      r.ch1 = 24'(s1);
      if (p_mode == MODE_REC) begin
        if (p_rec_pos < loop_limit()) begin
          loop0[p_rec_pos] = s0;
          loop1[p_rec_pos] = s1;
          p_rec_pos++;
        end else begin
          close_loop(loop_limit());
        end
      end else if ((p_mode == MODE_PLAY || p_mode == MODE_ODUB) && p_len > 0) begin
        if (p_play_pos >= p_len) p_play_pos = 0;
        m0 = sat24(loop0[p_play_pos] + s0);
        m1 = sat24(loop1[p_play_pos] + s1);
        if (p_mode == MODE_ODUB) begin
          loop0[p_play_pos] = m0;
          loop1[p_play_pos] = m1;
        end
        r.ch0 = 24'(m0);
        r.ch1 = 24'(m1);
        p_play_pos++;
        if (p_play_pos >= p_len) p_play_pos = 0;
      end
    end
    r.mode = p_mode;
    r.loop_len = p_len[16:0];
    r.undo_cnt = p_undo[2:0];
    return r;
  endfunction

  // Short, rare long, and calm stretches without any gap
  function automatic int pick_gap();
    int r;
    if ((sent_count / 250) % 3 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until the transfer; record what it must give
  task automatic send_item(logic [2:0] op, logic [23:0] s0, logic [23:0] s1,
                           bit typed, looper_result_t typed_res);
    looper_result_t r;
    int             gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {s1, s0};
    do @(posedge clk); while (!in_tready);
    r = predict_looper(op, int'($signed(s0)), int'($signed(s1)));
    expected_q.push_back(typed ? typed_res : r);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [2:0] op, logic [23:0] s0, logic [23:0] s1);
    looper_result_t none;
    none = '{default: '0};
    send_item(op, s0, s1, 1'b0, none);
  endtask

  function automatic logic [23:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h7FFFFF;
    if (r == 1) return 24'h800000;
    return 24'($urandom());
  endfunction

  // Drain the block, then write the loop limit while it sits idle
  task automatic set_limit(logic [16:0] value);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    p_max_samples = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // One session: clear, record a loop of random length, then play with it
  task automatic run_session(logic [16:0] lim);
    int unsigned cap, frames, extra, r;
    session_count++;
    set_limit(lim);
    send_op(OP_CLEAR, rand_sample(), rand_sample());
    send_op(OP_REC, rand_sample(), rand_sample());
    cap = (lim > 200) ? 200 : lim + 2;
    frames = $urandom_range(0, cap);
    repeat (frames) send_op(OP_FRAME, rand_sample(), rand_sample());
    if ($urandom_range(0, 3) != 0) send_op(OP_REC, rand_sample(), rand_sample());
    extra = $urandom_range(20, 90);
    repeat (extra) begin
      r = $urandom_range(0, 99);
      if (r < 68)      send_op(OP_FRAME, rand_sample(), rand_sample());
      else if (r < 77) send_op(OP_ODUB, rand_sample(), rand_sample());
      else if (r < 85) send_op(OP_UNDO, rand_sample(), rand_sample());
      else if (r < 92) send_op(OP_PLAY, rand_sample(), rand_sample());
      else if (r < 96) send_op(OP_REC, rand_sample(), rand_sample());
      else if (r < 98) send_op(OP_CLEAR, rand_sample(), rand_sample());
      else             send_op($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7,
                               rand_sample(), rand_sample());
    end
  endtask

  // Receiver: random stalls, one long hold-off to back up the input side
  int  hold_cycles = 0;
  bit  pressure_done = 1'b0;
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!pressure_done && sent_count >= 200) begin
      pressure_done = 1'b1;
      hold_cycles = 400;
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if ((sent_count / 250) % 3 == 1) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 12) hold_cycles = $urandom_range(1, 3);
      else if (r < 14) hold_cycles = $urandom_range(10, 40);
      out_tready <= (hold_cycles == 0);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    looper_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      recv_count++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: %h", out_tdata);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[23:0] !== e.ch0) begin
          $error("out_ch0: expected %0d, actual %0d", e.ch0, $signed(out_tdata[23:0]));
          fail_count++;
        end
        if (out_tdata[47:24] !== e.ch1) begin
          $error("out_ch1: expected %0d, actual %0d", e.ch1, $signed(out_tdata[47:24]));
          fail_count++;
        end
        if (out_tdata[50:48] !== e.mode) begin
          $error("mode: expected %0d, actual %0d", e.mode, out_tdata[50:48]);
          fail_count++;
        end
        if (out_tdata[67:51] !== e.loop_len) begin
          $error("loop_length: expected %0d, actual %0d", e.loop_len, out_tdata[67:51]);
          fail_count++;
        end
        if (out_tdata[70:68] !== e.undo_cnt) begin
          $error("undo_available: expected %0d, actual %0d", e.undo_cnt, out_tdata[70:68]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  stim_row_t rows[$];

  function automatic void add_row(logic [2:0] op, logic [23:0] s0, logic [23:0] s1, bit typed,
                                  logic [23:0] e0, logic [23:0] e1, logic [2:0] md);
    stim_row_t row;
    row.op = op; row.s0 = s0; row.s1 = s1; row.typed = typed;
    row.res = '{ch0: e0, ch1: e1, mode: md, loop_len: '0, undo_cnt: '0};
    rows.push_back(row);
  endfunction

  initial begin
    clear_looper();
    p_max_samples = 17'd65536;
    for (int i = 0; i < DEPTH; i++) begin
      loop0[i] = 0;
      loop1[i] = 0;
    end

    // Pass-through and ignored commands while empty
    add_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000, MODE_EMPTY);
    add_row(OP_FRAME, 24'h800000, 24'h7FFFFF, 1, 24'h800000, 24'h7FFFFF, MODE_EMPTY);
    add_row(OP_SPARE6, 24'hFFFFFF, 24'hFFFFFF, 1, '0, '0, MODE_EMPTY);
    add_row(OP_SPARE7, 24'hFFFFFF, 24'hFFFFFF, 1, '0, '0, MODE_EMPTY);
    add_row(OP_PLAY,  '0, '0, 1, '0, '0, MODE_EMPTY);
    add_row(OP_ODUB,  '0, '0, 1, '0, '0, MODE_EMPTY);
    add_row(OP_UNDO,  '0, '0, 1, '0, '0, MODE_EMPTY);
    // Short loops are discarded
    add_row(OP_REC,   '0, '0, 1, '0, '0, MODE_REC);
    add_row(OP_REC,   '0, '0, 1, '0, '0, MODE_EMPTY);
    add_row(OP_REC,   '0, '0, 1, '0, '0, MODE_REC);
    add_row(OP_FRAME, 24'h123456, 24'hABCDEF, 0, '0, '0, '0);
    add_row(OP_REC,   '0, '0, 1, '0, '0, MODE_EMPTY);
    // Record a short loop at full scale, close it with the splice fade
    add_row(OP_REC,   '0, '0, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h800000, 24'h7FFFFF, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h400000, 24'hC00000, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h7FFFFF, 24'h7FFFFF, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h800000, 24'h800000, 0, '0, '0, '0);
    add_row(OP_REC,   '0, '0, 0, '0, '0, '0);
    // Saturating play, overdub, undo, stop and resume, clear
    add_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 0, '0, '0, '0);
    add_row(OP_ODUB,  '0, '0, 0, '0, '0, '0);
    add_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 0, '0, '0, '0);
    add_row(OP_UNDO,  '0, '0, 0, '0, '0, '0);
    add_row(OP_PLAY,  '0, '0, 0, '0, '0, '0);
    add_row(OP_PLAY,  '0, '0, 0, '0, '0, '0);
    add_row(OP_CLEAR, '0, '0, 1, '0, '0, MODE_EMPTY);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].op, rows[i].s0, rows[i].s1, rows[i].typed, rows[i].res);

    // Loop-limit extremes first, then mostly small limits
    run_session(17'd1);
    run_session(17'd65536);
    run_session(17'd2);
    run_session(17'd3);
    run_session(17'd4);
    while (sent_count < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1:    run_session(17'($urandom_range(1, 8)));
        2:       run_session(17'($urandom_range(129, 65536)));
        default: run_session(17'($urandom_range(4, 128)));
      endcase
    end

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d items in %0d sessions with %0d results checked.",
             sent_count, session_count, recv_count);
    $display("Loop limits from 1 to 65536, loop-full closes, overdub, undo, clear and stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
design/alr_pkg.sv
design/alr_ram.sv
design/alr_div.sv
design/alr_dp.sv
design/alr_ctrl.sv
design/audio_loop_recorder_overdub_unit.sv
tb/audio_loop_recorder_overdub_unit_tb.sv
